// ----- hw/rtl/lzwve_pkg.sv -----
// Shared types and constants of the LZW variable-width encoder.
package lzwve_pkg;

  localparam int unsigned MaxCodeWidthDefault = 12;
  localparam int unsigned DictEntriesDefault  = 4096;

  localparam int unsigned CodeBusW   = 17;
  localparam int unsigned GenW       = 4;
  localparam int unsigned AccW       = 32;
  localparam int unsigned CntW       = 5;
  localparam int unsigned WidthW     = 5;

  localparam int unsigned CodeReset      = 'h100;
  localparam int unsigned CodeEnd        = 'h101;
  localparam int unsigned FirstFree      = 'h102;
  localparam int unsigned StartThreshold = 'h200;
  localparam int unsigned StartWidth     = 9;

  typedef enum logic [1:0] {
    CMD_CODE  = 2'd0,
    CMD_END   = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [WidthW-1:0]     width;
    logic [CodeBusW-1:0]   code;
  } pack_cmd_t;

endpackage

// ----- hw/rtl/lzwve_if.sv -----
// Valid/ready channel interfaces for the input bytes and the packed output bytes.
interface lzwve_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_last;

  modport source (output valid, output data_byte, output stream_last, input ready);
  modport sink (input valid, input data_byte, input stream_last, output ready);
endinterface

interface lzwve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       run_last;
  logic       stream_end;

  modport source (output valid, output packed_byte, output run_last, output stream_end,
                  input ready);
  modport sink (input valid, input packed_byte, input run_last, input stream_end,
                output ready);
endinterface

// ----- hw/rtl/lzw_variable_width_encoder.sv -----
// Top level of the LZW variable-width encoder: match sequencer, dictionary memory and packer.
// Each input byte is one transaction; the encoder takes one byte at a time and holds off the
// next until the current one has been matched and its codes handed to the packer. A byte that
// extends the current match is looked up in the hash table, which is a single-port memory of
// twice DictEntries slots with a registered read and linear probing; the first byte of a stream
// needs no probe. A byte that ends a match also outputs a code and writes the dictionary, plus
// the reset code when the dictionary is cleared, and the last byte of a stream also sends the
// end code and the flush. A code waits while the packer holds sixteen bits or more or is still
// sending the bytes of the previous transaction. After reset, and on every fifteenth dictionary
// clear (the end of each stream clears it too), a clearing pass sweeps all 2 * DictEntries
// slots of the memory, during which no byte is taken. Packed output bytes leave through a
// registered output stage, one per cycle while the receiver is ready, while the next byte is
// being matched.
module lzw_variable_width_encoder #(
  parameter int unsigned MaxCodeWidth = lzwve_pkg::MaxCodeWidthDefault,
  parameter int unsigned DictEntries  = lzwve_pkg::DictEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzwve_in_if.sink    in_i,
  lzwve_out_if.source out_o
);
  import lzwve_pkg::*;

  localparam int unsigned PfxW   = MaxCodeWidth + 1;
  localparam int unsigned KeyW   = PfxW + 8;
  localparam int unsigned SlotW  = $clog2(DictEntries) + 1;
  localparam int unsigned EntryW = GenW + KeyW + PfxW;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_START, S_LOOKUP, S_PROBE, S_EMITP, S_ADD, S_RSTC, S_LAST,
    S_ENDC, S_FIN
  } state_e;

  state_e            state_q, state_d, ret_q, ret_d;
  logic [7:0]        byte_q, byte_d;
  logic              last_q, last_d;
  logic [PfxW-1:0]   prefix_q, prefix_d;
  logic              pvalid_q, pvalid_d;
  logic              started_q, started_d;
  logic [PfxW-1:0]   nf_q, nf_d, nf_next;
  logic [WidthW-1:0] width_q, width_d;
  logic [PfxW-1:0]   thresh_q, thresh_d;
  logic [GenW-1:0]   gen_q, gen_d;
  logic [SlotW-1:0]  slot_q, slot_d;

  logic [EntryW-1:0] mem [2**SlotW];
  logic [EntryW-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [SlotW-1:0]  mem_addr;
  logic [EntryW-1:0] mem_wdata;

  logic              cmd_valid, cmd_ready;
  pack_cmd_t         cmd;
  logic [KeyW-1:0]   key;
  logic [SlotW-1:0]  hslot;
  logic [GenW-1:0]   e_gen;
  logic [KeyW-1:0]   e_key;
  logic [PfxW-1:0]   e_code;

  function automatic logic [SlotW-1:0] slot_hash(input logic [KeyW-1:0] k);
    logic [SlotW-1:0] h;
    h = '0;
    for (int i = 0; i < KeyW; i++) begin
      h[i % SlotW] = h[i % SlotW] ^ k[i];
    end
    return h;
  endfunction

  assign key     = {prefix_q, byte_q};
  assign hslot   = slot_hash(key);
  assign e_gen   = rdata_q[EntryW-1 -: GenW];
  assign e_key   = rdata_q[PfxW +: KeyW];
  assign e_code  = rdata_q[PfxW-1:0];
  assign nf_next = nf_q + PfxW'(1);
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    byte_d    = byte_q;
    last_d    = last_q;
    prefix_d  = prefix_q;
    pvalid_d  = pvalid_q;
    started_d = started_q;
    nf_d      = nf_q;
    width_d   = width_q;
    thresh_d  = thresh_q;
    gen_d     = gen_q;
    slot_d    = slot_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = slot_q;
    mem_wdata = {gen_q, key, nf_q};
    cmd_valid = 1'b0;
    cmd.kind  = CMD_CODE;
    cmd.width = width_q;
    cmd.code  = CodeBusW'(prefix_q);
    case (state_q)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        slot_d    = slot_q + SlotW'(1);
        if (slot_q == '1) begin
          gen_d   = GenW'(1);
          state_d = ret_q;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          byte_d  = in_i.data_byte;
          last_d  = in_i.stream_last;
          state_d = S_START;
        end
      end
      S_START: begin
        if (!started_q) begin
          cmd_valid = 1'b1;
          cmd.code  = CodeBusW'(CodeReset);
          if (cmd_ready) begin
            started_d = 1'b1;
            state_d   = S_LOOKUP;
          end
        end else begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (!pvalid_q) begin
          prefix_d = PfxW'(byte_q);
          pvalid_d = 1'b1;
          state_d  = S_LAST;
        end else begin
          mem_re   = 1'b1;
          mem_addr = hslot;
          slot_d   = hslot;
          state_d  = S_PROBE;
        end
      end
      S_PROBE: begin
        if (e_gen != gen_q) begin
          state_d = S_EMITP;
        end else if (e_key == key) begin
          prefix_d = e_code;
          state_d  = S_LAST;
        end else begin
          mem_re   = 1'b1;
          mem_addr = slot_q + SlotW'(1);
          slot_d   = slot_q + SlotW'(1);
        end
      end
      S_EMITP: begin
        cmd_valid = 1'b1;
        if (cmd_ready) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        mem_we   = (32'(nf_q) < 32'(DictEntries));
        nf_d     = nf_next;
        prefix_d = PfxW'(byte_q);
        state_d  = S_LAST;
        if (nf_next > thresh_q) begin
          if (width_q >= WidthW'(MaxCodeWidth)) begin
            state_d = S_RSTC;
          end else begin
            width_d  = width_q + WidthW'(1);
            thresh_d = thresh_q << 1;
          end
        end
      end
      S_RSTC: begin
        cmd_valid = 1'b1;
        cmd.code  = CodeBusW'(CodeReset);
        if (cmd_ready) begin
          nf_d     = PfxW'(FirstFree);
          width_d  = WidthW'(StartWidth);
          thresh_d = PfxW'(StartThreshold);
          if (gen_q == '1) begin
            slot_d  = '0;
            ret_d   = S_LAST;
            state_d = S_SWEEP;
          end else begin
            gen_d   = gen_q + GenW'(1);
            state_d = S_LAST;
          end
        end
      end
      S_LAST: begin
        cmd_valid = 1'b1;
        if (last_q) begin
          if (cmd_ready) begin
            state_d = S_ENDC;
          end
        end else begin
          cmd.kind = CMD_END;
          if (cmd_ready) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ENDC: begin
        cmd_valid = 1'b1;
        cmd.code  = CodeBusW'(CodeEnd);
        if (cmd_ready) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_valid = 1'b1;
        cmd.kind  = CMD_FLUSH;
        if (cmd_ready) begin
          started_d = 1'b0;
          pvalid_d  = 1'b0;
          prefix_d  = '0;
          nf_d      = PfxW'(FirstFree);
          width_d   = WidthW'(StartWidth);
          thresh_d  = PfxW'(StartThreshold);
          if (gen_q == '1) begin
            slot_d  = '0;
            ret_d   = S_IDLE;
            state_d = S_SWEEP;
          end else begin
            gen_d   = gen_q + GenW'(1);
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SWEEP;
      ret_q     <= S_IDLE;
      byte_q    <= '0;
      last_q    <= 1'b0;
      prefix_q  <= '0;
      pvalid_q  <= 1'b0;
      started_q <= 1'b0;
      nf_q      <= PfxW'(FirstFree);
      width_q   <= WidthW'(StartWidth);
      thresh_q  <= PfxW'(StartThreshold);
      gen_q     <= GenW'(1);
      slot_q    <= '0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      byte_q    <= byte_d;
      last_q    <= last_d;
      prefix_q  <= prefix_d;
      pvalid_q  <= pvalid_d;
      started_q <= started_d;
      nf_q      <= nf_d;
      width_q   <= width_d;
      thresh_q  <= thresh_d;
      gen_q     <= gen_d;
      slot_q    <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  lzwve_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_o       (out_o)
  );

endmodule

// ----- hw/rtl/lzwve_packer.sv -----
// Bit packer that turns variable-width codes into LSB-first bytes with end flags.
module lzwve_packer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  lzwve_pkg::pack_cmd_t cmd_i,
  lzwve_out_if.source          out_o
);
  import lzwve_pkg::*;

  logic [AccW-1:0]     acc_q, acc_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                end_q, end_d;
  logic                flush_q, flush_d;
  logic                ovalid_q, ovalid_d;
  logic [7:0]          byte_q, byte_d;
  logic                rl_q, rl_d;
  logic                se_q, se_d;
  logic                can_load;
  logic [CodeBusW-1:0] masked;

  assign can_load    = !ovalid_q || out_o.ready;
  assign cmd_ready_o = !end_q && (cnt_q < CntW'(16));

  always_comb begin
    for (int i = 0; i < CodeBusW; i++) begin
      masked[i] = cmd_i.code[i] & (i < int'(cmd_i.width));
    end
  end

  always_comb begin
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    end_d    = end_q;
    flush_d  = flush_q;
    byte_d   = byte_q;
    rl_d     = rl_q;
    se_d     = se_q;
    ovalid_d = out_o.ready ? 1'b0 : ovalid_q;
    if (end_q) begin
      if (cnt_q >= CntW'(8)) begin
        if (can_load) begin
          ovalid_d = 1'b1;
          byte_d   = acc_q[7:0];
          rl_d     = (cnt_q < CntW'(16)) && !(flush_q && (cnt_q > CntW'(8)));
          se_d     = rl_d && flush_q;
          acc_d    = acc_q >> 8;
          cnt_d    = cnt_q - CntW'(8);
        end
      end else if (flush_q && (cnt_q != '0)) begin
        if (can_load) begin
          ovalid_d = 1'b1;
          byte_d   = acc_q[7:0];
          rl_d     = 1'b1;
          se_d     = 1'b1;
          acc_d    = '0;
          cnt_d    = '0;
          end_d    = 1'b0;
        end
      end else begin
        end_d = 1'b0;
        if (flush_q) begin
          acc_d = '0;
          cnt_d = '0;
        end
      end
    end else if (cnt_q >= CntW'(16)) begin
      if (can_load) begin
        ovalid_d = 1'b1;
        byte_d   = acc_q[7:0];
        rl_d     = 1'b0;
        se_d     = 1'b0;
        acc_d    = acc_q >> 8;
        cnt_d    = cnt_q - CntW'(8);
      end
    end else if (cmd_valid_i) begin
      case (cmd_i.kind)
        CMD_CODE: begin
          acc_d = acc_q | (AccW'(masked) << cnt_q);
          cnt_d = cnt_q + CntW'(cmd_i.width);
        end
        CMD_END: begin
          end_d   = 1'b1;
          flush_d = 1'b0;
        end
        CMD_FLUSH: begin
          end_d   = 1'b1;
          flush_d = 1'b1;
        end
        default: begin
          end_d = end_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      cnt_q    <= '0;
      end_q    <= 1'b0;
      flush_q  <= 1'b0;
      ovalid_q <= 1'b0;
      byte_q   <= '0;
      rl_q     <= 1'b0;
      se_q     <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      end_q    <= end_d;
      flush_q  <= flush_d;
      ovalid_q <= ovalid_d;
      byte_q   <= byte_d;
      rl_q     <= rl_d;
      se_q     <= se_d;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.packed_byte = byte_q;
  assign out_o.run_last    = rl_q;
  assign out_o.stream_end  = se_q;

endmodule

// ----- tb/sv/tb_lzw_variable_width_encoder.sv -----
// Testbench for the LZW variable-width encoder: random byte streams checked against a predictor.
`timescale 1ns / 100ps
module tb_lzw_variable_width_encoder;
  import lzwve_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_last;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       run_last;
    logic       stream_end;
  } packed_item_t;

  logic clk_i;
  logic rst_ni;

  lzwve_in_if  in_if ();
  lzwve_out_if out_if ();

  lzw_variable_width_encoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  byte_item_t   pending_bytes[$];
  packed_item_t expected_bytes[$];
  int           error_count;
  int           bytes_sent;
  int           bytes_seen;
  int           streams_sent;

  // Predictor state; the dictionary is an associative array keyed by {prefix, byte}.
  int unsigned  dict_codes[int unsigned];
  int unsigned  cur_prefix;
  bit           have_prefix;
  bit           opened;
  int unsigned  free_code;
  int unsigned  cur_width;
  int unsigned  threshold;
  int unsigned  acc_bits;
  int unsigned  acc_count;
  packed_item_t step_out[$];

  function automatic void clear_codes();
    dict_codes.delete();
    free_code = FirstFree;
    cur_width = StartWidth;
    threshold = StartThreshold;
  endfunction

  function automatic void restart_encoder();
    clear_codes();
    cur_prefix  = 0;
    have_prefix = 0;
    opened      = 0;
    acc_bits    = 0;
    acc_count   = 0;
  endfunction

  function automatic void push_byte(int unsigned b);
    packed_item_t r;
    if (step_out.size() < 8) begin
      r.packed_byte = b[7:0];
      r.run_last    = 1'b0;
      r.stream_end  = 1'b0;
      step_out.push_back(r);
    end
  endfunction

  function automatic void push_code(int unsigned code);
    longint unsigned acc;
    int unsigned     bits;
    acc  = longint'(acc_bits) | (longint'(code & ((1 << cur_width) - 1)) << acc_count);
    bits = acc_count + cur_width;
    while (bits >= 8) begin
      push_byte(acc[7:0]);
      acc  = acc >> 8;
      bits = bits - 8;
    end
    acc_bits  = acc[6:0];
    acc_count = bits;
  endfunction

  function automatic void predict_codes(byte_item_t it);
    int unsigned key;
    step_out.delete();
    if (!opened) begin
      push_code(CodeReset);
      opened = 1;
    end
    if (!have_prefix) begin
      cur_prefix  = it.data_byte;
      have_prefix = 1;
    end else begin
      key = (cur_prefix << 8) | it.data_byte;
      if (dict_codes.exists(key)) begin
        cur_prefix = dict_codes[key];
      end else begin
        push_code(cur_prefix);
        if (free_code < DictEntriesDefault) dict_codes[key] = free_code;
        free_code++;
        if (free_code > threshold) begin
          if (cur_width >= MaxCodeWidthDefault) begin
            push_code(CodeReset);
            clear_codes();
          end else begin
            cur_width++;
            threshold = threshold << 1;
          end
        end
        cur_prefix = it.data_byte;
      end
    end
    if (it.stream_last) begin
      push_code(cur_prefix);
      push_code(CodeEnd);
      if (acc_count > 0) push_byte(acc_bits);
      restart_encoder();
    end
    if (step_out.size() > 0) begin
      step_out[step_out.size()-1].run_last = 1'b1;
      if (it.stream_last) step_out[step_out.size()-1].stream_end = 1'b1;
    end
    foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
  endfunction

  function automatic void add_stream(int len, int mode);
    byte_item_t it;
    byte        alphabet;
    alphabet = byte'($urandom_range(1, 6));
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: it.data_byte = 8'($urandom_range(0, alphabet));
        1: it.data_byte = 8'($urandom);
        default: it.data_byte = 8'h41 + 8'($urandom_range(0, 1));
      endcase
      it.stream_last = (i == len - 1);
      pending_bytes.push_back(it);
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.data_byte   <= 8'h00;
      in_if.stream_last <= 1'b0;
      burst_left        <= 0;
      gap_left          <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_codes('{in_if.data_byte, in_if.stream_last});
        bytes_sent <= bytes_sent + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left    <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_if.valid       <= 1'b1;
          in_if.data_byte   <= pending_bytes[0].data_byte;
          in_if.stream_last <= pending_bytes[0].stream_last;
          void'(pending_bytes.pop_front());
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: the receiver stalls on a slowly changing random pattern.
  int stall_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_mode   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        bytes_seen <= bytes_seen + 1;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte %h run_last %b stream_end %b", $time,
                   out_if.packed_byte, out_if.run_last, out_if.stream_end);
          error_count++;
        end else begin
          if (out_if.packed_byte !== expected_bytes[0].packed_byte ||
              out_if.run_last !== expected_bytes[0].run_last ||
              out_if.stream_end !== expected_bytes[0].stream_end) begin
            $display("%0t: expected byte %h run_last %b stream_end %b, got %h %b %b",
                     $time, expected_bytes[0].packed_byte, expected_bytes[0].run_last,
                     expected_bytes[0].stream_end, out_if.packed_byte, out_if.run_last,
                     out_if.stream_end);
            error_count++;
          end
          void'(expected_bytes.pop_front());
        end
      end
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ($urandom_range(0, 1) != 0);
        default: out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    error_count  = 0;
    bytes_sent   = 0;
    bytes_seen   = 0;
    restart_encoder();
    rst_ni = 1'b0;
    // Directed: single-byte streams at the extremes, repeats, a classic pattern.
    pending_bytes.push_back('{8'h00, 1'b1});
    pending_bytes.push_back('{8'hff, 1'b1});
    for (int i = 0; i < 6; i++) pending_bytes.push_back('{8'hff, i == 5});
    for (int i = 0; i < 8; i++) pending_bytes.push_back('{(i % 2) ? 8'h55 : 8'haa, 1'b0});
    for (int i = 0; i < 6; i++) pending_bytes.push_back('{8'h00, i == 5});
    streams_sent = 4;
    // A long stream of random bytes widens the codes from 9 to 10 bits.
    add_stream(300, 1);
    streams_sent++;
    // Short random streams, mostly low-entropy content so matches grow.
    while (pending_bytes.size() < 345) begin
      add_stream($urandom_range(1, 12), $urandom_range(0, 2));
      streams_sent++;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_bytes.size() == 0 && !in_if.valid);
    wait (expected_bytes.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d bytes in %0d streams, checked %0d packed bytes.",
             bytes_sent, streams_sent, bytes_seen);
    $display("Streams of one byte, repeats and a long one that widens codes to 10 bits.");
    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("tb_lzw_variable_width_encoder passed");
    end else begin
      $display("tb_lzw_variable_width_encoder failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_lzw_variable_width_encoder failed");
    $finish;
  end

endmodule
